[sv/hcl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and hex helpers for the hex command line parser.
// Depends on nothing; every other file refers to it by scoped names.
package hcl_pkg;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam int MAX_DIGITS_DEFAULT   = 16;
    localparam int PAYLOAD_W            = 64;
    localparam int NIBBLES              = PAYLOAD_W / 4;

    // One finished line as reported on the result channel
    typedef struct packed {
        logic                 line_valid;
        logic [7:0]           node_id;
        logic [PAYLOAD_W-1:0] payload;
        logic                 payload_updated;
    } t_line_result;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70) ||
               (c >= 8'd97 && c <= 8'd102);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = c - 8'd48;
        end else if (c >= 8'd65 && c <= 8'd70) begin
            v = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd102) begin
            v = c - 8'd87;
        end
        return v[3:0];
    endfunction

endpackage

[sv/hcl_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the hex command line parser: received bytes in,
// finished line reports out. Depends on hcl_pkg for the result width.
interface hcl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcl_line_if;
    logic                          valid;
    logic                          ready;
    logic                          line_valid;
    logic [7:0]                    node_id;
    logic [hcl_pkg::PAYLOAD_W-1:0] payload;
    logic                          payload_updated;

    modport source (output valid, output line_valid, output node_id, output payload,
                    output payload_updated, input ready);
    modport sink   (input valid, input line_valid, input node_id, input payload,
                    input payload_updated, output ready);
endinterface

[sv/hcl_parse.sv]
`timescale 1ns / 1ps
// Per-byte line parser: tracks phase, id, payload digits and parity of the
// current line and forms the line report at the newline. Depends on hcl_pkg.
module hcl_parse #(
    parameter int MAX_DIGITS = hcl_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_skip_parity,
    output logic                  o_done,
    output hcl_pkg::t_line_result o_result
);

    localparam logic [2:0] PH_ID      = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_DIGITS  = 3'd2;
    localparam logic [2:0] PH_PARITY  = 3'd3;
    localparam logic [2:0] PH_SENSOR  = 3'd4;
    localparam logic [2:0] PH_STOPPED = 3'd5;

    localparam logic [4:0] DIGIT_SAT = 5'(hcl_pkg::NIBBLES);
    localparam logic [4:0] DIGIT_MAX = 5'(MAX_DIGITS);

    logic [2:0]                    r_phase,   n_phase;
    logic [2:0]                    r_len,     n_len;
    logic [7:0]                    r_id,      n_id;
    logic                          r_sec_tab, n_sec_tab;
    logic [hcl_pkg::PAYLOAD_W-1:0] r_acc,     n_acc;
    logic [4:0]                    r_digits,  n_digits;
    logic [7:0]                    r_par,     n_par;
    logic [1:0]                    r_par_cnt, n_par_cnt;
    logic                          r_cmd_err, n_cmd_err;
    logic [hcl_pkg::PAYLOAD_W-1:0] r_held,    n_held;

    logic        is_newline;
    logic        is_tab;
    logic        is_hex;
    logic [3:0]  nib;
    logic        valid;
    logic        updated;
    logic        parity_ok;
    logic [15:0] calc;

    assign is_newline = (i_byte == hcl_pkg::CHAR_NEWLINE);
    assign is_tab     = (i_byte == hcl_pkg::CHAR_TAB);
    assign is_hex     = hcl_pkg::hex_ok(i_byte);
    assign nib        = hcl_pkg::hex_val(i_byte);
    assign o_done     = i_accept && is_newline;

    // Verdict for the line ending at this newline
    assign calc      = r_acc[15:0] ^ {8'd0, r_id};
    assign parity_ok = (r_phase == PH_PARITY) && (r_par_cnt == 2'd2) && !r_cmd_err &&
                       (calc == {8'd0, r_par});

    always_comb begin
        valid   = 1'b0;
        updated = 1'b0;
        if (r_len != 3'd0) begin
            if (r_len >= 3'd4 && r_sec_tab) begin
                valid   = i_skip_parity || parity_ok;
                updated = valid;
            end else begin
                valid = 1'b1;
            end
        end
    end

    // Advance line state on each accepted byte; clear it at the newline
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_id      = r_id;
        n_sec_tab = r_sec_tab;
        n_acc     = r_acc;
        n_digits  = r_digits;
        n_par     = r_par;
        n_par_cnt = r_par_cnt;
        n_cmd_err = r_cmd_err;
        n_held    = r_held;
        if (i_accept) begin
            if (is_newline) begin
                if (updated) begin
                    n_held = r_acc;
                end
                n_phase   = PH_ID;
                n_len     = 3'd0;
                n_id      = 8'd0;
                n_sec_tab = 1'b0;
                n_acc     = '0;
                n_digits  = 5'd0;
                n_par     = 8'd0;
                n_par_cnt = 2'd0;
                n_cmd_err = 1'b0;
            end else begin
                if (r_len < 3'd4) begin
                    n_len = r_len + 3'd1;
                end
                unique case (r_phase)
                    PH_ID: begin
                        n_id    = i_byte;
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_sec_tab = is_tab;
                        n_phase   = is_tab ? PH_DIGITS : PH_SENSOR;
                    end
                    PH_DIGITS: begin
                        if (is_tab) begin
                            n_phase = PH_PARITY;
                        end else if (is_hex) begin
                            if (r_digits < DIGIT_MAX && r_digits < DIGIT_SAT) begin
                                n_acc[{r_digits[3:0], 2'b00} +: 4] = nib;
                            end
                            if (r_digits < DIGIT_SAT) begin
                                n_digits = r_digits + 5'd1;
                            end
                        end else begin
                            n_cmd_err = 1'b1;
                            n_phase   = PH_STOPPED;
                        end
                    end
                    PH_PARITY: begin
                        if (r_par_cnt < 2'd2) begin
                            n_par     = {r_par[3:0], nib};
                            n_par_cnt = r_par_cnt + 2'd1;
                        end else begin
                            n_cmd_err = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_len     <= 3'd0;
            r_id      <= 8'd0;
            r_sec_tab <= 1'b0;
            r_acc     <= '0;
            r_digits  <= 5'd0;
            r_par     <= 8'd0;
            r_par_cnt <= 2'd0;
            r_cmd_err <= 1'b0;
            r_held    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_id      <= n_id;
            r_sec_tab <= n_sec_tab;
            r_acc     <= n_acc;
            r_digits  <= n_digits;
            r_par     <= n_par;
            r_par_cnt <= n_par_cnt;
            r_cmd_err <= n_cmd_err;
            r_held    <= n_held;
        end
    end

    assign o_result.line_valid      = valid;
    assign o_result.node_id         = valid ? r_id : 8'd0;
    assign o_result.payload         = n_held;
    assign o_result.payload_updated = updated;

    // Counters stay within their saturation limits
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 3'd4) else $error("line length past saturation");
    a_digit_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= DIGIT_SAT) else $error("digit count past saturation");
    // A tab in second place sends the line into the command phases
    a_tab_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_tab |-> (r_phase == PH_DIGITS || r_phase == PH_PARITY ||
                       r_phase == PH_STOPPED)) else $error("tab flag outside command phase");
    // Newline restarts the line
    a_newline_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_phase == PH_ID && r_len == 3'd0 && !r_cmd_err))
        else $error("line state not cleared at newline");
    // Held payload only moves on a reported update
    a_held_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && updated) |=> $stable(r_held)) else $error("held payload changed");

endmodule

[sv/hex_command_line_parser.sv]
`timescale 1ns / 1ps
// Top level of the hex command line parser: byte channel in, line report
// channel out, one configuration bit. Depends on hcl_pkg, hcl_if, hcl_parse.
//
// Usage:
//   i_rx carries received bytes (valid/ready). Byte 10 ends a line; each
//   newline yields exactly one transaction on o_line, other bytes none.
//   o_line reports line_valid, the object id (0 when invalid), the held
//   64-bit command payload after the line, and whether the line replaced it.
//   i_cfg_we / i_cfg_wdata write the skip-parity bit; write it while idle.
// Timing:
//   One byte is taken every cycle unless a report waits on o_line. Each
//   byte updates the line state in the cycle it is accepted; a newline's
//   report is loaded into the output register at that edge and appears
//   on o_line in the cycle after. Throughput is one byte per cycle.
// Stall and reset:
//   While a report waits on o_line with ready low, i_rx.ready drops and the
//   report holds. Synchronous reset (i_rst_n low) clears the line state,
//   the held payload, the skip-parity bit and the output valid flag.
module hex_command_line_parser #(
    parameter int MAX_DIGITS = hcl_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    hcl_byte_if.sink          i_rx,
    hcl_line_if.source        o_line
);

    logic                  r_skip_parity;
    logic                  r_out_valid;
    hcl_pkg::t_line_result r_out;
    logic                  accept;
    logic                  done;
    hcl_pkg::t_line_result line_res;

    // Take a byte whenever the output register is free or draining
    assign i_rx.ready = !r_out_valid || o_line.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    hcl_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (i_rx.rx_byte),
        .i_skip_parity (r_skip_parity),
        .o_done        (done),
        .o_result      (line_res)
    );

    // Hold the configuration bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_parity <= 1'b0;
        end else if (i_cfg_we) begin
            r_skip_parity <= i_cfg_wdata;
        end
    end

    // Load the report at a newline; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_line.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= line_res;
        end
    end

    assign o_line.valid           = r_out_valid;
    assign o_line.line_valid      = r_out.line_valid;
    assign o_line.node_id         = r_out.node_id;
    assign o_line.payload         = r_out.payload;
    assign o_line.payload_updated = r_out.payload_updated;

endmodule

[sim/hcl_line_checker.sv]
`timescale 1ns / 1ps
// Line report checker for the hex command line parser: watches the byte and
// report channels, predicts each report and compares. Depends on hcl_pkg, hcl_if.
module hcl_line_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    hcl_byte_if   i_rx,
    hcl_line_if   i_line,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int LEN_SAT    = 4;
    localparam int DIGITS_CAP = 16;
    localparam int KEPT_MAX   = hcl_pkg::MAX_DIGITS_DEFAULT;

    localparam logic [2:0] SCAN_ID      = 3'd0;
    localparam logic [2:0] SCAN_SECOND  = 3'd1;
    localparam logic [2:0] SCAN_DIGITS  = 3'd2;
    localparam logic [2:0] SCAN_PARITY  = 3'd3;
    localparam logic [2:0] SCAN_SENSOR  = 3'd4;
    localparam logic [2:0] SCAN_STOPPED = 3'd5;

    // Parser state as the predictor tracks it
    logic [2:0]                    scan;
    int                            line_len;
    logic [7:0]                    line_id;
    logic                          second_tab;
    logic [hcl_pkg::PAYLOAD_W-1:0] digit_acc;
    int                            digit_cnt;
    logic [7:0]                    parity_acc;
    int                            parity_cnt;
    logic                          cmd_bad;
    logic [hcl_pkg::PAYLOAD_W-1:0] held_payload;
    logic                          skip_parity;

    hcl_pkg::t_line_result reports_due[$];
    int                    mismatches = 0;
    int                    reports_seen = 0;
    int                    pending_now = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_now;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] report %0d mismatch: %s", $time, reports_seen, msg);
        mismatches++;
    endtask

    function automatic logic decode_hex(input logic [7:0] ch, output logic [3:0] nib);
        nib = 4'h0;
        if (ch >= "0" && ch <= "9") begin
            nib = ch[3:0];
            return 1'b1;
        end
        if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
            nib = ch[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_line_state();
        scan       = SCAN_ID;
        line_len   = 0;
        line_id    = 8'h00;
        second_tab = 1'b0;
        digit_acc  = '0;
        digit_cnt  = 0;
        parity_acc = 8'h00;
        parity_cnt = 0;
        cmd_bad    = 1'b0;
    endtask

    // Advance the line state by one byte; a newline queues the expected report
    task automatic parse_rx_byte(input logic [7:0] ch);
        logic [3:0]            nib;
        logic                  is_hex;
        logic                  ok;
        logic                  took;
        hcl_pkg::t_line_result rep;
        if (ch != hcl_pkg::CHAR_NEWLINE) begin
            if (line_len < LEN_SAT) line_len++;
            is_hex = decode_hex(ch, nib);
            unique case (scan)
                SCAN_ID: begin
                    line_id = ch;
                    scan    = SCAN_SECOND;
                end
                SCAN_SECOND: begin
                    second_tab = (ch == hcl_pkg::CHAR_TAB);
                    scan       = second_tab ? SCAN_DIGITS : SCAN_SENSOR;
                end
                SCAN_DIGITS: begin
                    if (ch == hcl_pkg::CHAR_TAB) begin
                        scan = SCAN_PARITY;
                    end else if (is_hex) begin
                        if (digit_cnt < KEPT_MAX) digit_acc[6'(4*digit_cnt) +: 4] = nib;
                        if (digit_cnt < DIGITS_CAP) digit_cnt++;
                    end else begin
                        cmd_bad = 1'b1;
                        scan    = SCAN_STOPPED;
                    end
                end
                SCAN_PARITY: begin
                    // non-hex parity characters contribute a zero nibble
                    if (parity_cnt < 2) begin
                        parity_acc = {parity_acc[3:0], nib};
                        parity_cnt++;
                    end else begin
                        cmd_bad = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            ok   = 1'b0;
            took = 1'b0;
            if (line_len >= 1) begin
                if (line_len >= LEN_SAT && second_tab) begin
                    if (skip_parity) begin
                        ok = 1'b1;
                    end else if (scan == SCAN_PARITY && parity_cnt == 2 && !cmd_bad) begin
                        ok = ((digit_acc[15:0] ^ {8'h00, line_id}) == {8'h00, parity_acc});
                    end
                    if (ok) begin
                        held_payload = digit_acc;
                        took         = 1'b1;
                    end
                end else begin
                    ok = 1'b1;
                end
            end
            rep.line_valid      = ok;
            rep.node_id         = ok ? line_id : 8'h00;
            rep.payload         = held_payload;
            rep.payload_updated = took;
            reports_due.push_back(rep);
            clear_line_state();
        end
    endtask

    // Compare one accepted report with the oldest expectation
    task automatic check_report();
        hcl_pkg::t_line_result want;
        if (reports_due.size() == 0) begin
            flag_mismatch("report with nothing expected");
        end else begin
            want = reports_due.pop_front();
            if (i_line.line_valid !== want.line_valid)
                flag_mismatch($sformatf("line_valid got %0b want %0b",
                                        i_line.line_valid, want.line_valid));
            if (i_line.node_id !== want.node_id)
                flag_mismatch($sformatf("node_id got %02h want %02h",
                                        i_line.node_id, want.node_id));
            if (i_line.payload !== want.payload)
                flag_mismatch($sformatf("payload got %016h want %016h",
                                        i_line.payload, want.payload));
            if (i_line.payload_updated !== want.payload_updated)
                flag_mismatch($sformatf("payload_updated got %0b want %0b",
                                        i_line.payload_updated, want.payload_updated));
        end
        reports_seen++;
    endtask

    // Sample both channels and the config port at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            skip_parity  = 1'b0;
            held_payload = '0;
            clear_line_state();
            reports_due.delete();
        end else begin
            if (i_cfg_we) skip_parity = i_cfg_wdata;
            if (i_line.valid && i_line.ready) check_report();
            if (i_rx.valid && i_rx.ready) parse_rx_byte(i_rx.rx_byte);
        end
        pending_now = reports_due.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the hex command line parser: clock, reset, byte and config
// stimulus, report-side stalls, verdict. Depends on every other file in the project.
module tb_top;

    localparam int IDLE_LIMIT   = 400;
    localparam int PHASE_BYTES  = 180;
    localparam int PHASE_COUNT  = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    hcl_byte_if rx_ch ();
    hcl_line_if line_ch ();

    int fail_count;
    int pending;

    logic       rx_idle_en   = 1'b1;
    logic       line_idle_en = 1'b1;
    int         stall_left   = 0;
    int         quiet_cycles = 0;
    int         sent_bytes   = 0;
    logic [7:0] line_bytes[$];

    hex_command_line_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_line      (line_ch)
    );

    hcl_line_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx         (rx_ch),
        .i_line       (line_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the report side in short random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            line_ch.ready <= 1'b0;
        end else if (line_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            line_ch.ready <= 1'b0;
        end else begin
            line_ch.ready <= 1'b1;
        end
    end

    // End the run when neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (line_ch.valid && line_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == hcl_pkg::CHAR_NEWLINE);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Any byte that is neither a hex digit, a tab nor a newline
    function automatic logic [7:0] non_hex();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 8));
            1:       return 8'($urandom_range(11, 47));
            2:       return 8'($urandom_range(58, 64));
            3:       return 8'($urandom_range(71, 96));
            default: return 8'($urandom_range(103, 255));
        endcase
    endfunction

    // A zero parity nibble may also be spelled with a non-hex character
    function automatic logic [7:0] parity_char(input logic [3:0] nib);
        if (nib == 4'h0 && $urandom_range(0, 2) == 0) return non_hex();
        return hex_char(nib);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(negedge i_clk); while (!rx_ch.ready);
        @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    task automatic wait_reports_drained();
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Write the skip-parity bit once the parser is idle
    task automatic write_skip_parity(input logic v);
        rx_ch.valid <= 1'b0;
        wait_reports_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Build one random line, newline included, into line_bytes
    task automatic make_random_line();
        int          kind;
        int          ndig;
        int          flaw;
        int          n;
        int          i;
        logic [7:0]  id;
        logic [7:0]  par;
        logic [7:0]  b;
        logic [63:0] kept;
        logic [3:0]  nib;
        logic        zero_mid;
        line_bytes.delete();
        kind = $urandom_range(0, 99);
        id   = any_byte();
        if (kind < 55) begin
            // command: mostly well formed, some with one flaw
            ndig     = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20)
                                                   : $urandom_range(0, 15);
            zero_mid = ($urandom_range(0, 3) != 0);
            flaw     = $urandom_range(0, 9);
            kept     = '0;
            line_bytes.push_back(id);
            line_bytes.push_back(hcl_pkg::CHAR_TAB);
            for (i = 0; i < ndig; i++) begin
                nib = 4'($urandom);
                // keep digits 2 and 3 zero so the 16-bit parity can match
                if (zero_mid && (i == 2 || i == 3)) nib = 4'h0;
                if (i < 16) kept[6'(4*i) +: 4] = nib;
                line_bytes.push_back(hex_char(nib));
            end
            if (flaw == 7) begin
                line_bytes.push_back(non_hex());
                line_bytes.push_back(hex_char(4'($urandom)));
            end
            par = kept[7:0] ^ id;
            if (flaw == 6) par = par ^ (8'h01 << $urandom_range(0, 7));
            if (flaw == 8) begin
                if ($urandom_range(0, 1)) begin
                    line_bytes.push_back(hcl_pkg::CHAR_TAB);
                    line_bytes.push_back(parity_char(par[7:4]));
                end
            end else begin
                line_bytes.push_back(hcl_pkg::CHAR_TAB);
                line_bytes.push_back(parity_char(par[7:4]));
                line_bytes.push_back(parity_char(par[3:0]));
            end
            if (flaw == 9) begin
                n = $urandom_range(1, 3);
                repeat (n) line_bytes.push_back(any_byte());
            end
        end else if (kind < 80) begin
            // sensor packet
            line_bytes.push_back(id);
            do b = any_byte(); while (b == hcl_pkg::CHAR_TAB);
            line_bytes.push_back(b);
            n = $urandom_range(0, 5);
            repeat (n) line_bytes.push_back(any_byte());
        end else if (kind < 90) begin
            // short line of one to three bytes
            n = $urandom_range(1, 3);
            line_bytes.push_back(id);
            if (n >= 2) line_bytes.push_back($urandom_range(0, 1) ? hcl_pkg::CHAR_TAB
                                                                  : any_byte());
            if (n == 3) line_bytes.push_back(any_byte());
        end else if (kind >= 95) begin
            // noise heavy in tabs and hex digits
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) line_bytes.push_back(hcl_pkg::CHAR_TAB);
                else if ($urandom_range(0, 1)) line_bytes.push_back(hex_char(4'($urandom)));
                else line_bytes.push_back(any_byte());
            end
        end
        line_bytes.push_back(hcl_pkg::CHAR_NEWLINE);
    endtask

    initial begin
        int ph;
        int phase_end;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: empty, extreme ids, short, good and bad command
        line_bytes = '{hcl_pkg::CHAR_NEWLINE};
        send_line();
        line_bytes = '{8'hFF, hcl_pkg::CHAR_NEWLINE};
        send_line();
        line_bytes = '{8'h00, hcl_pkg::CHAR_TAB, "5", hcl_pkg::CHAR_NEWLINE};
        send_line();
        line_bytes = '{8'h05, hcl_pkg::CHAR_TAB, "3", hcl_pkg::CHAR_TAB, "0", "6",
                       hcl_pkg::CHAR_NEWLINE};
        send_line();
        line_bytes = '{8'h00, hcl_pkg::CHAR_TAB, "z", hcl_pkg::CHAR_TAB, "0", "0",
                       hcl_pkg::CHAR_NEWLINE};
        send_line();

        // Random phases alternating the skip-parity bit; last phase without idling
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_skip_parity(ph % 2 == 0);
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end) begin
                rx_idle_en   = (ph != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                line_idle_en = (ph != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                make_random_line();
                send_line();
            end
        end

        // Drain outstanding reports, then give the verdict
        rx_ch.valid <= 1'b0;
        wait_reports_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
